@@ hw/rtl/wbo_pkg.sv @@
`timescale 1ns / 1ps
package wbo_pkg;

    // Input item fields, packed into s_axis_tdata from bit 0 up
    localparam int PHASE_W  = 24;
    localparam int SHAPE_W  = 11;
    localparam int LSHAPE_W = 3;
    localparam int LINDEX_W = 11;
    localparam int LVALUE_W = 16;

    localparam int PHASE_LSB  = 0;
    localparam int SHAPE_LSB  = PHASE_LSB + PHASE_W;
    localparam int LSHAPE_LSB = SHAPE_LSB + SHAPE_W;
    localparam int LINDEX_LSB = LSHAPE_LSB + LSHAPE_W;
    localparam int LVALUE_LSB = LINDEX_LSB + LINDEX_W;
    localparam int IN_FIELDS_W = LVALUE_LSB + LVALUE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int OUT_TDATA_W = 16;

    // Shape position is Q3.8
    localparam int SHAPE_FRAC_BITS = 8;
    localparam int SHAPE_INT_BITS  = SHAPE_W - SHAPE_FRAC_BITS;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_RENDER = 1'b1
    } t_action;

endpackage

@@ hw/rtl/wbo_ram.sv @@
`timescale 1ns / 1ps
module wbo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

@@ hw/rtl/wavetable_bilinear_oscillator.sv @@
`timescale 1ns / 1ps
// Wavetable oscillator with bilinear interpolation. Each transaction on the slave stream is
// either a load (tuser = 0), which writes one sample into the wave bank and gives no result,
// or a render (tuser = 1), which reads two neighboring samples from each of two adjacent
// waveforms, interpolates along the phase and then across the shape fraction, and gives one
// signed sample on the master stream with tlast copied from the render transaction. The
// pipeline takes one transaction per clock while the skid register is empty; a render
// result reaches m_axis through seven register stages: phase scaling, address generation,
// the registered read of the wave bank, the phase multiply, the phase add, the shape
// multiply and the output register. The bank is split into even and odd waveforms, each
// with one write and two read ports, so the four reads of a render land in one cycle.
// Loads write in the same stage where renders read, so every render sees all loads sent
// before it. The wave bank is not cleared at reset; a render that touches a sample never
// loaded gives an undefined value. s_axis_tready drops only when a result is held on
// m_axis and a second one is waiting behind it in the skid register.
module wavetable_bilinear_oscillator
    import wbo_pkg::*;
#(
    parameter int WAVE_LENGTH = 2048,
    parameter int NUM_WAVES   = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // phase[23:0], shape[34:24], load_shape[37:35], load_index[48:38],
    // load_value[64:49], zero pad[71:65]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample[15:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    localparam int IW          = $clog2(WAVE_LENGTH);
    localparam int PW          = PHASE_BITS + IW;
    localparam int WAW         = $clog2(NUM_WAVES);
    localparam int EVEN_WAVES  = (NUM_WAVES + 1) / 2;
    localparam int ODD_WAVES   = NUM_WAVES / 2;
    localparam int EVEN_DEPTH  = EVEN_WAVES * WAVE_LENGTH;
    localparam int ODD_DEPTH   = ODD_WAVES * WAVE_LENGTH;
    localparam int EAW         = $clog2(EVEN_DEPTH);
    localparam int OAW         = $clog2(ODD_DEPTH);
    localparam int DW          = SAMPLE_BITS + 1;
    localparam int PRW         = DW + PHASE_BITS + 1;
    localparam int SPRW        = DW + SHAPE_FRAC_BITS + 1;
    localparam int SAT_W       = 25;
    localparam logic signed [SAT_W-1:0] SAT_HI =
        SAT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    // ---------------------------------------------------------------------------------------
    // Flow control: the whole pipeline advances unless the skid register is occupied.
    // ---------------------------------------------------------------------------------------
    logic r_s_v;
    logic r_o_v;
    logic en;
    logic accept;

    assign en            = !r_s_v;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    // Unpack the slave transaction
    logic [PHASE_W-1:0]  in_phase;
    logic [SHAPE_W-1:0]  in_shape;
    logic [LSHAPE_W-1:0] in_lshape;
    logic [LINDEX_W-1:0] in_lindex;
    logic [LVALUE_W-1:0] in_lvalue;
    logic                in_render;

    assign in_phase  = s_axis_tdata[PHASE_LSB  +: PHASE_W];
    assign in_shape  = s_axis_tdata[SHAPE_LSB  +: SHAPE_W];
    assign in_lshape = s_axis_tdata[LSHAPE_LSB +: LSHAPE_W];
    assign in_lindex = s_axis_tdata[LINDEX_LSB +: LINDEX_W];
    assign in_lvalue = s_axis_tdata[LVALUE_LSB +: LVALUE_W];
    assign in_render = (t_action'(s_axis_tuser) == ACT_RENDER);

    // ---------------------------------------------------------------------------------------
    // Stage A: scale the phase to a table position (phase bits above PHASE_BITS drop out).
    // ---------------------------------------------------------------------------------------
    logic [PHASE_BITS-1:0] n_a_ph;
    logic [PW-1:0]         n_a_p;

    assign n_a_ph = PHASE_BITS'(in_phase);
    assign n_a_p  = PW'(n_a_ph) * PW'(WAVE_LENGTH);

    logic                r_a_v;
    logic                r_a_render;
    logic [PW-1:0]       r_a_p;
    logic [SHAPE_W-1:0]  r_a_shape;
    logic                r_a_last;
    logic [LSHAPE_W-1:0] r_a_lshape;
    logic [LINDEX_W-1:0] r_a_lindex;
    logic [LVALUE_W-1:0] r_a_lvalue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_render <= in_render;
            r_a_p      <= n_a_p;
            r_a_shape  <= in_shape;
            r_a_last   <= s_axis_tlast;
            r_a_lshape <= in_lshape;
            r_a_lindex <= in_lindex;
            r_a_lvalue <= in_lvalue;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage B: split position into index and fraction, decode shape, form bank addresses.
    // ---------------------------------------------------------------------------------------
    logic [IW-1:0]              n_b_idx;
    logic [IW-1:0]              n_b_nxt;
    logic [PHASE_BITS-1:0]      n_b_f;
    logic [SHAPE_INT_BITS-1:0]  n_b_sint;
    logic                       n_b_clamp;
    logic [WAW-1:0]             n_b_wa;
    logic [WAW:0]               n_b_wa_inc;
    logic [WAW:0]               n_b_wave_e;
    logic [WAW:0]               n_b_wave_o;
    logic [WAW-1:0]             n_b_row_e;
    logic [WAW-1:0]             n_b_row_o;
    logic [SHAPE_FRAC_BITS-1:0] n_b_sf;

    assign n_b_idx  = r_a_p[PHASE_BITS +: IW];
    assign n_b_f    = r_a_p[PHASE_BITS-1:0];
    // Wrap past the last entry to entry zero
    assign n_b_nxt  = (n_b_idx == IW'(WAVE_LENGTH - 1)) ? '0 : n_b_idx + IW'(1);

    assign n_b_sint  = r_a_shape[SHAPE_FRAC_BITS +: SHAPE_INT_BITS];
    // Shape at or past the last waveform: pin to it, fraction zero
    assign n_b_clamp = (32'(n_b_sint) >= 32'(NUM_WAVES - 1));
    assign n_b_wa    = n_b_clamp ? WAW'(NUM_WAVES - 1) : WAW'(n_b_sint);
    assign n_b_sf    = n_b_clamp ? '0 : r_a_shape[SHAPE_FRAC_BITS-1:0];

    // Waveform wa sits in the bank of its parity, wa+1 in the other bank
    assign n_b_wa_inc = {1'b0, n_b_wa} + (WAW + 1)'(1);
    assign n_b_wave_e = n_b_wa[0] ? n_b_wa_inc : {1'b0, n_b_wa};
    assign n_b_wave_o = n_b_wa[0] ? {1'b0, n_b_wa} : n_b_wa_inc;
    assign n_b_row_e  = (n_b_clamp && n_b_wa[0])  ? '0 : n_b_wave_e[WAW:1];
    assign n_b_row_o  = (n_b_clamp && !n_b_wa[0]) ? '0 : n_b_wave_o[WAW:1];

    logic [EAW-1:0] n_b_ra_e0;
    logic [EAW-1:0] n_b_ra_e1;
    logic [OAW-1:0] n_b_ra_o0;
    logic [OAW-1:0] n_b_ra_o1;

    assign n_b_ra_e0 = EAW'(32'(n_b_row_e) * WAVE_LENGTH + 32'(n_b_idx));
    assign n_b_ra_e1 = EAW'(32'(n_b_row_e) * WAVE_LENGTH + 32'(n_b_nxt));
    assign n_b_ra_o0 = OAW'(32'(n_b_row_o) * WAVE_LENGTH + 32'(n_b_idx));
    assign n_b_ra_o1 = OAW'(32'(n_b_row_o) * WAVE_LENGTH + 32'(n_b_nxt));

    // Load path: range check, saturate, address in the bank of the waveform's parity
    logic                          n_b_lok;
    logic [LSHAPE_W-2:0]           n_b_lrow;
    logic [EAW-1:0]                n_b_wa_e;
    logic [OAW-1:0]                n_b_wa_o;
    logic signed [SAT_W-1:0]       n_b_lv;
    logic signed [SAT_W-1:0]       n_b_lsat;

    assign n_b_lok  = r_a_v && !r_a_render
                   && (32'(r_a_lshape) < 32'(NUM_WAVES))
                   && (32'(r_a_lindex) < 32'(WAVE_LENGTH));
    assign n_b_lrow = r_a_lshape[LSHAPE_W-1:1];
    assign n_b_wa_e = EAW'(32'(n_b_lrow) * WAVE_LENGTH + 32'(r_a_lindex));
    assign n_b_wa_o = OAW'(32'(n_b_lrow) * WAVE_LENGTH + 32'(r_a_lindex));
    assign n_b_lv   = SAT_W'($signed(r_a_lvalue));
    assign n_b_lsat = (n_b_lv > SAT_HI) ? SAT_HI : ((n_b_lv < SAT_LO) ? SAT_LO : n_b_lv);

    logic                       r_b_v;
    logic                       r_b_we_e;
    logic                       r_b_we_o;
    logic [EAW-1:0]             r_b_wa_e;
    logic [OAW-1:0]             r_b_wa_o;
    logic [SAMPLE_BITS-1:0]     r_b_wdata;
    logic [EAW-1:0]             r_b_ra_e0;
    logic [EAW-1:0]             r_b_ra_e1;
    logic [OAW-1:0]             r_b_ra_o0;
    logic [OAW-1:0]             r_b_ra_o1;
    logic                       r_b_par;
    logic                       r_b_clamp;
    logic [PHASE_BITS-1:0]      r_b_f;
    logic [SHAPE_FRAC_BITS-1:0] r_b_sf;
    logic                       r_b_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v    <= 1'b0;
            r_b_we_e <= 1'b0;
            r_b_we_o <= 1'b0;
        end else if (en) begin
            r_b_v    <= r_a_v && r_a_render;
            r_b_we_e <= n_b_lok && !r_a_lshape[0];
            r_b_we_o <= n_b_lok && r_a_lshape[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_wa_e  <= n_b_wa_e;
            r_b_wa_o  <= n_b_wa_o;
            r_b_wdata <= SAMPLE_BITS'(n_b_lsat);
            r_b_ra_e0 <= n_b_ra_e0;
            r_b_ra_e1 <= n_b_ra_e1;
            r_b_ra_o0 <= n_b_ra_o0;
            r_b_ra_o1 <= n_b_ra_o1;
            r_b_par   <= n_b_wa[0];
            r_b_clamp <= n_b_clamp;
            r_b_f     <= n_b_f;
            r_b_sf    <= n_b_sf;
            r_b_last  <= r_a_last;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage C: wave bank access. Loads write and renders read in this one stage.
    // ---------------------------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] c_e0;
    logic [SAMPLE_BITS-1:0] c_e1;
    logic [SAMPLE_BITS-1:0] c_o0;
    logic [SAMPLE_BITS-1:0] c_o1;

    wbo_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (EVEN_DEPTH)
    ) u_bank_even (
        .i_clk    (i_clk),
        .i_we     (en && r_b_we_e),
        .i_waddr  (r_b_wa_e),
        .i_wdata  (r_b_wdata),
        .i_re     (en),
        .i_raddr0 (r_b_ra_e0),
        .i_raddr1 (r_b_ra_e1),
        .o_rdata0 (c_e0),
        .o_rdata1 (c_e1)
    );

    wbo_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (ODD_DEPTH)
    ) u_bank_odd (
        .i_clk    (i_clk),
        .i_we     (en && r_b_we_o),
        .i_waddr  (r_b_wa_o),
        .i_wdata  (r_b_wdata),
        .i_re     (en),
        .i_raddr0 (r_b_ra_o0),
        .i_raddr1 (r_b_ra_o1),
        .o_rdata0 (c_o0),
        .o_rdata1 (c_o1)
    );

    logic                       r_c_v;
    logic                       r_c_par;
    logic                       r_c_clamp;
    logic [PHASE_BITS-1:0]      r_c_f;
    logic [SHAPE_FRAC_BITS-1:0] r_c_sf;
    logic                       r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_par   <= r_b_par;
            r_c_clamp <= r_b_clamp;
            r_c_f     <= r_b_f;
            r_c_sf    <= r_b_sf;
            r_c_last  <= r_b_last;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage D: route bank outputs to the two waveforms, multiply slopes by phase fraction.
    // ---------------------------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] n_d_a0;
    logic signed [SAMPLE_BITS-1:0] n_d_a1;
    logic signed [SAMPLE_BITS-1:0] n_d_b0;
    logic signed [SAMPLE_BITS-1:0] n_d_b1;
    logic signed [DW-1:0]          n_d_da;
    logic signed [DW-1:0]          n_d_db;
    logic signed [PHASE_BITS:0]    n_d_f;

    assign n_d_a0 = r_c_par ? c_o0 : c_e0;
    assign n_d_a1 = r_c_par ? c_o1 : c_e1;
    // Clamped shape uses the last waveform twice
    assign n_d_b0 = r_c_clamp ? n_d_a0 : (r_c_par ? c_e0 : c_o0);
    assign n_d_b1 = r_c_clamp ? n_d_a1 : (r_c_par ? c_e1 : c_o1);
    assign n_d_da = DW'(n_d_a1) - DW'(n_d_a0);
    assign n_d_db = DW'(n_d_b1) - DW'(n_d_b0);
    assign n_d_f  = $signed({1'b0, r_c_f});

    logic                          r_d_v;
    logic signed [PRW-1:0]         r_d_pa;
    logic signed [PRW-1:0]         r_d_pb;
    logic signed [SAMPLE_BITS-1:0] r_d_a0;
    logic signed [SAMPLE_BITS-1:0] r_d_b0;
    logic [SHAPE_FRAC_BITS-1:0]    r_d_sf;
    logic                          r_d_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_pa   <= PRW'(n_d_da) * PRW'(n_d_f);
            r_d_pb   <= PRW'(n_d_db) * PRW'(n_d_f);
            r_d_a0   <= n_d_a0;
            r_d_b0   <= n_d_b0;
            r_d_sf   <= r_c_sf;
            r_d_last <= r_c_last;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage E: add the floored phase terms to the base samples.
    // ---------------------------------------------------------------------------------------
    logic signed [DW-1:0] n_e_va;
    logic signed [DW-1:0] n_e_vb;

    assign n_e_va = DW'(r_d_a0) + DW'(r_d_pa >>> PHASE_BITS);
    assign n_e_vb = DW'(r_d_b0) + DW'(r_d_pb >>> PHASE_BITS);

    logic                          r_e_v;
    logic signed [SAMPLE_BITS-1:0] r_e_va;
    logic signed [SAMPLE_BITS-1:0] r_e_vb;
    logic [SHAPE_FRAC_BITS-1:0]    r_e_sf;
    logic                          r_e_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_va   <= SAMPLE_BITS'(n_e_va);
            r_e_vb   <= SAMPLE_BITS'(n_e_vb);
            r_e_sf   <= r_d_sf;
            r_e_last <= r_d_last;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stage F: multiply the waveform difference by the shape fraction.
    // ---------------------------------------------------------------------------------------
    logic signed [DW-1:0]              n_f_dv;
    logic signed [SHAPE_FRAC_BITS:0]   n_f_sf;

    assign n_f_dv = DW'(r_e_vb) - DW'(r_e_va);
    assign n_f_sf = $signed({1'b0, r_e_sf});

    logic                          r_f_v;
    logic signed [SPRW-1:0]        r_f_p;
    logic signed [SAMPLE_BITS-1:0] r_f_va;
    logic                          r_f_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_p    <= SPRW'(n_f_dv) * SPRW'(n_f_sf);
            r_f_va   <= r_e_va;
            r_f_last <= r_e_last;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Output register with skid: a stalled result waits here, the next one waits in the skid.
    // ---------------------------------------------------------------------------------------
    logic signed [DW-1:0]          n_o_sum;
    logic signed [SAMPLE_BITS-1:0] n_o_r;
    logic [OUT_TDATA_W-1:0]        n_o_data;

    assign n_o_sum  = DW'(r_f_va) + DW'(r_f_p >>> SHAPE_FRAC_BITS);
    assign n_o_r    = SAMPLE_BITS'(n_o_sum);
    assign n_o_data = OUT_TDATA_W'(n_o_r);

    logic [OUT_TDATA_W-1:0] r_o_data;
    logic                   r_o_last;
    logic [OUT_TDATA_W-1:0] r_s_data;
    logic                   r_s_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (!r_s_v) begin
            if (!r_o_v || m_axis_tready) begin
                r_o_v <= r_f_v;
            end else if (r_f_v) begin
                r_s_v <= 1'b1;
            end
        end else if (m_axis_tready) begin
            // drain skid into the output register
            r_s_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_s_v) begin
            if (!r_o_v || m_axis_tready) begin
                r_o_data <= n_o_data;
                r_o_last <= r_f_last;
            end else begin
                r_s_data <= n_o_data;
                r_s_last <= r_f_last;
            end
        end else if (m_axis_tready) begin
            r_o_data <= r_s_data;
            r_o_last <= r_s_last;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

endmodule

@@ hw/rtl/wbo_checker.sv @@
`timescale 1ns / 1ps
module wbo_checker
    import wbo_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Reset empties the output and skid registers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    // Input backpressure only follows an output stall
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("tready dropped without an output stall");

    // A full skid implies a result on the output
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("skid holds data behind an empty output");

endmodule

bind wavetable_bilinear_oscillator wbo_checker u_wbo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
